/* sv/blsu_pkg.sv */
// ----------------------------------------------------------------------------
// blsu_pkg
// Shared constants, types and sizing helpers for the Bresenham line stepper.
// ----------------------------------------------------------------------------
package blsu_pkg;

    // Default coordinate width in bits (two's complement)
    localparam int COORD_BITS_DEF = 16;

    // Width of the packed RGB888 color
    localparam int COLOR_BITS = 24;

    // Entries in the queue between the setup front and the stepping back end
    localparam int QUEUE_DEPTH = 2;

    // Command codes carried on s_tuser
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // Status of the stepping back end, watched at the top level
    typedef struct packed {
        logic emit;    // a pixel is written to the output register
        logic last;    // that pixel is the final endpoint
        logic active;  // a line is in progress
    } blsu_stat_t;

    // Queue entry: start flag, steep flag, minor step sign, color,
    // minor delta, major delta, minor position, major end, major position
    // (the two deltas are one bit wider than a coordinate)
    function automatic int qentry_bits(input int cb);
        return 3 * cb + 2 * (cb + 1) + 3 + COLOR_BITS;
    endfunction

    // Round a bit count up to whole bytes
    function automatic int byte_round(input int bits);
        return ((bits + 7) / 8) * 8;
    endfunction

endpackage

/* sv/blsu_front.sv */
// ----------------------------------------------------------------------------
// blsu_front
// Classifies an incoming item and, for a start, sets up the line: picks the
// major axis, orders the endpoints along it and forms deltas and step sign.
// ----------------------------------------------------------------------------
module blsu_front
    import blsu_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                                  cmd,
    input  logic signed [COORD_BITS-1:0]          from_x,
    input  logic signed [COORD_BITS-1:0]          from_y,
    input  logic signed [COORD_BITS-1:0]          to_x,
    input  logic signed [COORD_BITS-1:0]          to_y,
    input  logic        [COLOR_BITS-1:0]          color,
    output logic        [qentry_bits(COORD_BITS)-1:0] entry
);

    localparam int CB = COORD_BITS;

    logic signed [CB:0]   dx;
    logic signed [CB:0]   dy;
    logic        [CB:0]   adx;
    logic        [CB:0]   ady;
    logic                 steep;
    logic signed [CB-1:0] a0;
    logic signed [CB-1:0] a1;
    logic signed [CB-1:0] b0;
    logic signed [CB-1:0] b1;
    logic signed [CB:0]   dmaj;
    logic signed [CB:0]   dmin;
    logic                 swap;
    logic                 minor_neg;
    logic signed [CB-1:0] major_pos;
    logic signed [CB-1:0] major_end;
    logic signed [CB-1:0] minor_pos;
    logic        [CB:0]   major_delta;
    logic        [CB:0]   minor_delta;
    logic                 is_start;

    // Signed differences and their magnitudes
    assign dx  = {to_x[CB-1], to_x} - {from_x[CB-1], from_x};
    assign dy  = {to_y[CB-1], to_y} - {from_y[CB-1], from_y};
    assign adx = dx[CB] ? (~dx + 1'b1) : dx;
    assign ady = dy[CB] ? (~dy + 1'b1) : dy;

    // Steep when |dy| exceeds |dx|; a tie stays shallow
    assign steep = (ady > adx);

    // Swap axes for a steep line
    assign a0   = steep ? from_y : from_x;
    assign a1   = steep ? to_y   : to_x;
    assign b0   = steep ? from_x : from_y;
    assign b1   = steep ? to_x   : to_y;
    assign dmaj = steep ? dy : dx;
    assign dmin = steep ? dx : dy;

    // Order endpoints along the major axis
    assign swap      = dmaj[CB];
    assign major_pos = swap ? a1 : a0;
    assign major_end = swap ? a0 : a1;
    assign minor_pos = swap ? b1 : b0;

    // Minor step goes down unless the ordered minor coordinate rises
    assign minor_neg = swap ? !dmin[CB] : (dmin[CB] || (dmin == '0));

    assign major_delta = steep ? ady : adx;
    assign minor_delta = steep ? adx : ady;
    assign is_start    = (cmd == CMD_START);

    // Pack the classified item for the queue
    assign entry = {is_start, steep, minor_neg, color, minor_delta, major_delta,
                    minor_pos, major_end, major_pos};

endmodule

/* sv/blsu_queue.sv */
// ----------------------------------------------------------------------------
// blsu_queue
// Short first-in first-out queue that decouples setup from stepping; a push
// and a pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module blsu_queue
    import blsu_pkg::*;
#(
    parameter int WIDTH = qentry_bits(COORD_BITS_DEF)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data,
    output logic             full
);

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(QUEUE_DEPTH - 1);

    logic [WIDTH-1:0]    slot_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;

    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == CNT_BITS'(QUEUE_DEPTH));
    assign head_data  = slot_reg[rd_ptr_reg];

    // Advance pointers with wrap, track fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* sv/blsu_back.sv */
// ----------------------------------------------------------------------------
// blsu_back
// Stepping engine: holds the active line, takes one queued item per cycle
// while the output register can take a pixel, emits the current pixel into
// the output register and advances one major step with the error-term update.
// ----------------------------------------------------------------------------
module blsu_back
    import blsu_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  head_valid,
    input  logic        [qentry_bits(COORD_BITS)-1:0] head_data,
    output logic                                  pop,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [COORD_BITS-1:0]          pixel_x,
    output logic signed [COORD_BITS-1:0]          pixel_y,
    output logic        [COLOR_BITS-1:0]          pixel_color,
    output logic                                  last_pixel,
    output blsu_stat_t                            stat
);

    localparam int CB = COORD_BITS;
    localparam logic [CB-1:0] ONE = {{(CB-1){1'b0}}, 1'b1};

    // Unpacked head entry
    logic                  h_start;
    logic                  h_steep;
    logic                  h_neg;
    logic [COLOR_BITS-1:0] h_color;
    logic [CB:0]           h_mind;
    logic [CB:0]           h_majd;
    logic [CB-1:0]         h_min;
    logic [CB-1:0]         h_end;
    logic [CB-1:0]         h_maj;

    // Line state
    logic                  active_reg,  active_next;
    logic                  steep_reg,   steep_next;
    logic [CB-1:0]         maj_reg,     maj_next;
    logic [CB-1:0]         end_reg,     end_next;
    logic [CB-1:0]         min_reg,     min_next;
    logic [CB:0]           majd_reg,    majd_next;
    logic [CB:0]           mind_reg,    mind_next;
    logic signed [CB+1:0]  err_reg,     err_next;
    logic                  neg_reg,     neg_next;
    logic [COLOR_BITS-1:0] color_reg,   color_next;

    // Output register
    logic                  ovalid_reg,  ovalid_next;
    logic [CB-1:0]         ox_reg,      ox_next;
    logic [CB-1:0]         oy_reg,      oy_next;
    logic [COLOR_BITS-1:0] ocolor_reg,  ocolor_next;
    logic                  olast_reg,   olast_next;

    // Working values of the pixel being emitted
    logic                  cur_steep;
    logic [CB-1:0]         cur_maj;
    logic [CB-1:0]         cur_end;
    logic [CB-1:0]         cur_min;
    logic [CB:0]           cur_majd;
    logic [CB:0]           cur_mind;
    logic signed [CB+1:0]  cur_err;
    logic                  cur_neg;
    logic [COLOR_BITS-1:0] cur_color;
    logic signed [CB+1:0]  mind_ext;
    logic signed [CB+1:0]  majd_ext;
    logic signed [CB+1:0]  err_sub;
    logic signed [CB+1:0]  err_add;
    logic                  minor_move;
    logic                  is_last;
    logic                  emit;

    assign {h_start, h_steep, h_neg, h_color, h_mind, h_majd, h_min, h_end, h_maj}
        = head_data;

    // Take the head whenever the output register can take a pixel
    assign pop  = head_valid && (!ovalid_reg || out_ready);
    assign emit = pop && (h_start || active_reg);

    // A start supplies fresh setup, a step continues the held line
    assign cur_steep = h_start ? h_steep : steep_reg;
    assign cur_maj   = h_start ? h_maj   : maj_reg;
    assign cur_end   = h_start ? h_end   : end_reg;
    assign cur_min   = h_start ? h_min   : min_reg;
    assign cur_majd  = h_start ? h_majd  : majd_reg;
    assign cur_mind  = h_start ? h_mind  : mind_reg;
    assign cur_err   = h_start ? $signed({2'b00, h_majd[CB:1]}) : err_reg;
    assign cur_neg   = h_start ? h_neg   : neg_reg;
    assign cur_color = h_start ? h_color : color_reg;

    // Error update: subtract minor delta, add major delta back on a minor move
    assign mind_ext   = $signed({1'b0, cur_mind});
    assign majd_ext   = $signed({1'b0, cur_majd});
    assign err_sub    = cur_err - mind_ext;
    assign err_add    = cur_err - mind_ext + majd_ext;
    assign minor_move = err_sub[CB+1];
    assign is_last    = (cur_maj == cur_end);

    // Next line state
    always_comb
    begin
        active_next = active_reg;
        steep_next  = steep_reg;
        maj_next    = maj_reg;
        end_next    = end_reg;
        min_next    = min_reg;
        majd_next   = majd_reg;
        mind_next   = mind_reg;
        err_next    = err_reg;
        neg_next    = neg_reg;
        color_next  = color_reg;
        if (emit)
        begin
            steep_next = cur_steep;
            end_next   = cur_end;
            majd_next  = cur_majd;
            mind_next  = cur_mind;
            neg_next   = cur_neg;
            color_next = cur_color;
            if (is_last)
            begin
                active_next = 1'b0;
                maj_next    = cur_maj;
                min_next    = cur_min;
                err_next    = cur_err;
            end
            else
            begin
                active_next = 1'b1;
                maj_next    = cur_maj + ONE;
                err_next    = minor_move ? err_add : err_sub;
                if (minor_move)
                begin
                    min_next = cur_neg ? (cur_min - ONE) : (cur_min + ONE);
                end
                else
                begin
                    min_next = cur_min;
                end
            end
        end
    end

    // Load the output register on emit, drop it once transferred
    always_comb
    begin
        ovalid_next = ovalid_reg;
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        ocolor_next = ocolor_reg;
        olast_next  = olast_reg;
        if (emit)
        begin
            ovalid_next = 1'b1;
            ox_next     = cur_steep ? cur_min : cur_maj;
            oy_next     = cur_steep ? cur_maj : cur_min;
            ocolor_next = cur_color;
            olast_next  = is_last;
        end
        else if (out_ready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            steep_reg  <= 1'b0;
            maj_reg    <= '0;
            end_reg    <= '0;
            min_reg    <= '0;
            majd_reg   <= '0;
            mind_reg   <= '0;
            err_reg    <= '0;
            neg_reg    <= 1'b0;
            color_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            steep_reg  <= steep_next;
            maj_reg    <= maj_next;
            end_reg    <= end_next;
            min_reg    <= min_next;
            majd_reg   <= majd_next;
            mind_reg   <= mind_next;
            err_reg    <= err_next;
            neg_reg    <= neg_next;
            color_reg  <= color_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Output payload holds without reset
    always_ff @(posedge clk)
    begin
        ox_reg     <= ox_next;
        oy_reg     <= oy_next;
        ocolor_reg <= ocolor_next;
        olast_reg  <= olast_next;
    end

    assign out_valid   = ovalid_reg;
    assign pixel_x     = ox_reg;
    assign pixel_y     = oy_reg;
    assign pixel_color = ocolor_reg;
    assign last_pixel  = olast_reg;

    assign stat.emit   = emit;
    assign stat.last   = is_last;
    assign stat.active = active_reg;

endmodule

/* sv/bresenham_line_stepper_unit.sv */
// Path: an input transfer enters the queue, then its pixel is registered in the
// output register and shown on m_tvalid. Throughput: one item per cycle while
// m_tready is high; each step is one add and compare in the back end, and the
// two-entry queue plus the output register keep both sides moving independently.
// Reset: rst_n clears the queue, the line state and the output valid at once;
// no clearing pass, the block takes items from the first cycle after reset.
// ----------------------------------------------------------------------------
// bresenham_line_stepper_unit
// Integer Bresenham line rasterizer for all octants, built as a setup front,
// a short queue and a stepping back end with a registered output.
// ----------------------------------------------------------------------------
module bresenham_line_stepper_unit
    import blsu_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,

    // Input stream
    input  logic s_tvalid,
    output logic s_tready,
    // s_tdata, lowest bit up: from_x, from_y, to_x, to_y, color, zero pad
    input  logic [byte_round(4 * COORD_BITS + COLOR_BITS)-1:0] s_tdata,
    // s_tuser: cmd
    input  logic s_tuser,

    // Output stream
    output logic m_tvalid,
    input  logic m_tready,
    // m_tdata, lowest bit up: pixel_x, pixel_y, pixel_color, zero pad
    output logic [byte_round(2 * COORD_BITS + COLOR_BITS)-1:0] m_tdata,
    // m_tlast: last_pixel
    output logic m_tlast
);

    localparam int CB        = COORD_BITS;
    localparam int OUT_BITS  = 2 * CB + COLOR_BITS;
    localparam int OUT_TDATA = byte_round(OUT_BITS);
    localparam int QW        = qentry_bits(CB);

    logic signed [CB-1:0]  from_x;
    logic signed [CB-1:0]  from_y;
    logic signed [CB-1:0]  to_x;
    logic signed [CB-1:0]  to_y;
    logic [COLOR_BITS-1:0] color;
    logic [QW-1:0]         entry;
    logic                  q_full;
    logic                  q_push;
    logic                  q_pop;
    logic                  q_valid;
    logic [QW-1:0]         q_data;
    logic signed [CB-1:0]  pixel_x;
    logic signed [CB-1:0]  pixel_y;
    logic [COLOR_BITS-1:0] pixel_color;
    blsu_stat_t            back_stat;

    // Unpack input fields
    assign from_x = s_tdata[CB-1:0];
    assign from_y = s_tdata[2*CB-1:CB];
    assign to_x   = s_tdata[3*CB-1:2*CB];
    assign to_y   = s_tdata[4*CB-1:3*CB];
    assign color  = s_tdata[4*CB+COLOR_BITS-1:4*CB];

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready;

    blsu_front #(
        .COORD_BITS (CB)
    ) u_front (
        .cmd    (s_tuser),
        .from_x (from_x),
        .from_y (from_y),
        .to_x   (to_x),
        .to_y   (to_y),
        .color  (color),
        .entry  (entry)
    );

    blsu_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (entry),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_data),
        .full       (q_full)
    );

    blsu_back #(
        .COORD_BITS (CB)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (q_valid),
        .head_data   (q_data),
        .pop         (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_color (pixel_color),
        .last_pixel  (m_tlast),
        .stat        (back_stat)
    );

    // Pack output fields, zero pad to whole bytes
    assign m_tdata = OUT_TDATA'({pixel_color, pixel_y, pixel_x});

`ifndef NO_ASSERTIONS
    // Pop only from a non-empty queue
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
        else $error("queue popped while empty");

    // Never overwrite a pixel that is stalled in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !back_stat.emit)
        else $error("stalled output pixel overwritten");

    // A pixel that is not the endpoint leaves the line active
    assert property (@(posedge clk) disable iff (!rst_n)
        (back_stat.emit && !back_stat.last) |=> back_stat.active)
        else $error("line dropped before its endpoint");

    // Emitting the endpoint ends the line
    assert property (@(posedge clk) disable iff (!rst_n)
        (back_stat.emit && back_stat.last) |=> !back_stat.active)
        else $error("line still active after its endpoint");
`endif

endmodule
